@@ hdl/ssbd_pkg.sv @@
// ----------------------------------------------------------------------------
// ssbd_pkg: shared types and constants of the segment boundary detector
// Item layouts, configuration fields, register indexes, mode codes and
// sequencer states used by all modules of the block.
// ----------------------------------------------------------------------------
package ssbd_pkg;

  localparam int COUNT_WIDTH = 16;           // segment and row counters
  localparam int LIMIT_W     = 16;           // row-limit counter, saturates at 65535
  localparam int SAMPLE_W    = 32;           // Q16.16 sample
  localparam int DIVIDEND_W  = SAMPLE_W + 1; // magnitude of sample minus base
  localparam int DIVISOR_W   = 31;           // change_amount
  localparam int REGION_W    = DIVIDEND_W + 1;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_of_page;
  } ssbd_in_t;

  typedef struct packed {
    logic                   segment_start;
    logic [COUNT_WIDTH-1:0] segment_number;
    logic [COUNT_WIDTH-1:0] row_in_segment;
  } ssbd_out_t;

  typedef struct packed {
    logic [2:0]                 break_mode;
    logic [30:0]                gap_amount;
    logic [DIVISOR_W-1:0]       change_amount;
    logic signed [SAMPLE_W-1:0] change_base;
    logic                       base_given;
    logic [15:0]                row_limit;
  } ssbd_cfg_t;

  typedef enum logic [2:0] {
    REG_BREAK_MODE    = 3'd0,
    REG_GAP_AMOUNT    = 3'd1,
    REG_CHANGE_AMOUNT = 3'd2,
    REG_CHANGE_BASE   = 3'd3,
    REG_BASE_GIVEN    = 3'd4,
    REG_ROW_LIMIT     = 3'd5
  } ssbd_reg_t;

  typedef enum logic [2:0] {
    MODE_GAP       = 3'd0,
    MODE_INCREASE  = 3'd1,
    MODE_DECREASE  = 3'd2,
    MODE_CHANGE    = 3'd3,
    MODE_ROW_LIMIT = 3'd4
  } ssbd_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } ssbd_state_t;

endpackage

@@ hdl/ssbd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ssbd_cfg_regs: configuration register file
// APB-style register bank holding the mode and thresholds of the detector.
// ----------------------------------------------------------------------------
module ssbd_cfg_regs
  import ssbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output ssbd_cfg_t         cfg
);

  ssbd_cfg_t cfg_r;
  ssbd_cfg_t cfg_nxt;
  logic      wr_en;
  ssbd_reg_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = ssbd_reg_t'(paddr[ADDR_W-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_BREAK_MODE:    cfg_nxt.break_mode    = pwdata[2:0];
        REG_GAP_AMOUNT:    cfg_nxt.gap_amount    = pwdata[30:0];
        REG_CHANGE_AMOUNT: cfg_nxt.change_amount = pwdata[DIVISOR_W-1:0];
        REG_CHANGE_BASE:   cfg_nxt.change_base   = signed'(pwdata[SAMPLE_W-1:0]);
        REG_BASE_GIVEN:    cfg_nxt.base_given    = pwdata[0];
        REG_ROW_LIMIT:     cfg_nxt.row_limit     = pwdata[15:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BREAK_MODE:    prdata = {29'd0, cfg_r.break_mode};
      REG_GAP_AMOUNT:    prdata = {1'b0, cfg_r.gap_amount};
      REG_CHANGE_AMOUNT: prdata = {1'b0, cfg_r.change_amount};
      REG_CHANGE_BASE:   prdata = cfg_r.change_base;
      REG_BASE_GIVEN:    prdata = {31'd0, cfg_r.base_given};
      REG_ROW_LIMIT:     prdata = {16'd0, cfg_r.row_limit};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.break_mode    <= MODE_GAP;
      cfg_r.gap_amount    <= 31'd65536;
      cfg_r.change_amount <= '0;
      cfg_r.change_base   <= '0;
      cfg_r.base_given    <= 1'b0;
      cfg_r.row_limit     <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/ssbd_divider.sv @@
// ----------------------------------------------------------------------------
// ssbd_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses after the last.
// ----------------------------------------------------------------------------
module ssbd_divider
  import ssbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  count_r, count_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  take;

  assign trial     = {rem_r, quo_r[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign take      = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    if (start) begin
      busy_nxt  = 1'b1;
      count_nxt = '0;
      rem_nxt   = '0;
      quo_nxt   = dividend;
      dvs_nxt   = divisor;
    end else if (busy_r) begin
      rem_nxt   = take ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt   = {quo_r[DIVIDEND_W-2:0], take};
      count_nxt = count_r + 1'b1;
      if (count_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hdl/stream_segment_boundary_detector_unit.sv @@
// ----------------------------------------------------------------------------
// stream_segment_boundary_detector_unit: segment boundary detector, top level
// Marks where each signed Q16.16 sample starts a new segment of its page.
// ----------------------------------------------------------------------------
// The block takes one sample per item with a first-of-page flag and returns
// one result item: a segment start flag, the segment number within the page
// and the row position within the segment, both saturating at 16 bits. The
// break rule is set by break_mode (gap, increase, decrease, change, row limit).
// Each sample's region, trunc((sample - base) / change_amount), is kept for
// change mode; when change_amount is nonzero it comes from one restoring
// divider that yields one quotient bit per cycle, so an item then passes
// through accept, one divide step per bit of the 33-bit dividend, a step to
// see the divider's done flag, and finish. With change_amount zero no
// division runs and an item goes from accept straight to finish. The input
// is stalled while an item is in work; the result sits in an output
// register, so a new item is taken while a previous result still waits
// downstream. Write the configuration only while the block is idle.
// ----------------------------------------------------------------------------
module stream_segment_boundary_detector_unit
  import ssbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input items
  input  logic              in_valid,
  output logic              in_stall,
  input  ssbd_in_t          in_data,
  // result items
  output logic              out_valid,
  input  logic              out_stall,
  output ssbd_out_t         out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [LIMIT_W-1:0]     LIMIT_MAX = '1;

  ssbd_cfg_t cfg;

  ssbd_state_t state_r, state_nxt;

  // item in work
  logic signed [SAMPLE_W-1:0] smp_r;
  logic                       first_r;
  logic                       neg_r;

  // running page state
  logic signed [SAMPLE_W-1:0] prev_r;
  logic signed [REGION_W-1:0] last_region_r;
  logic signed [SAMPLE_W-1:0] page_base_r;
  logic [COUNT_WIDTH-1:0]     rows_r;
  logic [COUNT_WIDTH-1:0]     seg_r;
  logic [LIMIT_W-1:0]         limit_r;
  logic                       page_seen_r;

  logic      out_valid_r;
  ssbd_out_t out_data_r;

  logic                       accept;
  logic                       in_first;
  logic signed [SAMPLE_W-1:0] base;
  logic signed [DIVIDEND_W-1:0] diff;
  logic [DIVIDEND_W-1:0]      diff_mag;
  logic                       div_start;
  logic                       div_done;
  logic [DIVIDEND_W-1:0]      quotient;
  logic                       amount_zero;
  logic                       out_free;
  logic                       commit;
  logic signed [REGION_W-1:0] region;
  logic signed [DIVIDEND_W-1:0] step;
  logic [DIVIDEND_W-1:0]      step_mag;
  logic                       brk;
  logic                       start;

  ssbd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssbd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_mag),
    .divisor  (cfg.change_amount),
    .done     (div_done),
    .quotient (quotient)
  );

  assign amount_zero = (cfg.change_amount == '0);
  assign accept      = in_valid && !in_stall;

  // Treat the very first sample after reset as a page start.
  assign in_first = in_data.first_of_page || !page_seen_r;
  assign base     = cfg.base_given ? cfg.change_base
                  : (in_first ? in_data.sample : page_base_r);
  assign diff     = DIVIDEND_W'(in_data.sample) - DIVIDEND_W'(base);
  assign diff_mag = diff[DIVIDEND_W-1] ? DIVIDEND_W'(-diff) : DIVIDEND_W'(diff);
  assign div_start = accept && !amount_zero;

  // Restore the sign of the truncated quotient.
  always_comb begin
    if (amount_zero) begin
      region = '0;
    end else if (neg_r) begin
      region = -signed'({1'b0, quotient});
    end else begin
      region = signed'({1'b0, quotient});
    end
  end

  assign step     = DIVIDEND_W'(smp_r) - DIVIDEND_W'(prev_r);
  assign step_mag = step[DIVIDEND_W-1] ? DIVIDEND_W'(-step) : DIVIDEND_W'(step);

  // Break rule of the current mode; unused mode codes never break.
  always_comb begin
    case (cfg.break_mode)
      MODE_GAP:       brk = step_mag >= DIVIDEND_W'(cfg.gap_amount);
      MODE_INCREASE:  brk = smp_r > prev_r;
      MODE_DECREASE:  brk = smp_r < prev_r;
      MODE_CHANGE:    brk = amount_zero ? (smp_r != prev_r) : (region != last_region_r);
      MODE_ROW_LIMIT: brk = limit_r >= cfg.row_limit;
      default:        brk = 1'b0;
    endcase
  end

  assign start    = first_r || brk;
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == ST_FINISH) && out_free;

  // Sequencer: accept, wait for the divider when change_amount is nonzero, then hand off the result.
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = amount_zero ? ST_FINISH : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Page and counter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r        <= '0;
      last_region_r <= '0;
      page_base_r   <= '0;
      rows_r        <= '0;
      seg_r         <= '0;
      limit_r       <= '0;
      page_seen_r   <= 1'b0;
    end else begin
      if (accept && in_first) begin
        page_base_r <= in_data.sample;
      end
      if (commit) begin
        page_seen_r   <= 1'b1;
        prev_r        <= smp_r;
        last_region_r <= region;
        if (first_r) begin
          seg_r   <= '0;
          rows_r  <= '0;
          limit_r <= LIMIT_W'(1);
        end else if (start) begin
          if (seg_r != COUNT_MAX) begin
            seg_r <= seg_r + 1'b1;
          end
          rows_r  <= '0;
          limit_r <= LIMIT_W'(1);
        end else begin
          if (rows_r != COUNT_MAX) begin
            rows_r <= rows_r + 1'b1;
          end
          if (limit_r != LIMIT_MAX) begin
            limit_r <= limit_r + 1'b1;
          end
        end
      end
    end
  end

  // Hold the item in work.
  always_ff @(posedge clk) begin
    if (accept) begin
      smp_r   <= in_data.sample;
      first_r <= in_first;
      neg_r   <= diff[DIVIDEND_W-1];
    end
  end

  // Output register: load on commit, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r.segment_start <= start;
      if (first_r) begin
        out_data_r.segment_number <= '0;
        out_data_r.row_in_segment <= '0;
      end else if (start) begin
        out_data_r.segment_number <= (seg_r != COUNT_MAX) ? seg_r + 1'b1 : seg_r;
        out_data_r.row_in_segment <= '0;
      end else begin
        out_data_r.segment_number <= seg_r;
        out_data_r.row_in_segment <= (rows_r != COUNT_MAX) ? rows_r + 1'b1 : rows_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sim/stream_segment_boundary_detector_unit_tb.sv @@
// ----------------------------------------------------------------------------
// stream_segment_boundary_detector_unit_tb: self-checking bench of the detector
// Drives sample items with random idle and stall patterns on both channels,
// reprograms the break rule between phases over the register port, and checks
// every result item field by field against a typed result or an in-bench boundary predictor.
// ----------------------------------------------------------------------------
module stream_segment_boundary_detector_unit_tb;
  import ssbd_pkg::*;

  localparam int          LIMIT_CYCLES     = 1_500_000;
  localparam int          NUM_PHASES       = 10;
  localparam int          ITEMS_PER_PHASE  = 183;
  localparam int          SETTLE_CYCLES    = 80;
  localparam int          HOLDOFF_CYCLES   = 400;
  localparam int          COUNT_MAX        = (1 << COUNT_WIDTH) - 1;
  localparam int          LIMIT_MAX        = 65535;
  // break_mode codes outside the defined rules: no break is made
  localparam logic [2:0]  FIRST_SPARE_MODE = 3'd5;
  localparam logic [2:0]  LAST_SPARE_MODE  = 3'd7;

  // mode of each random phase; idle pattern of each phase is taken modulo 4
  localparam logic [2:0] PHASE_MODE [NUM_PHASES] = '{
    MODE_GAP, MODE_INCREASE, MODE_DECREASE, MODE_CHANGE, MODE_ROW_LIMIT,
    MODE_CHANGE, MODE_GAP, FIRST_SPARE_MODE, MODE_CHANGE, MODE_ROW_LIMIT
  };
  localparam int SEND_IDLE [4] = '{0, 86, 0, 19};
  localparam int RECV_IDLE [4] = '{0, 0, 86, 19};

  // one row of the directed table: a register write or a sample item,
  // optionally with the result typed in by hand
  typedef struct {
    bit          is_write;
    ssbd_reg_t   target;
    logic [31:0] value;
    ssbd_in_t    item;
    bit          has_typed;
    ssbd_out_t   typed_res;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  ssbd_in_t          in_data;
  logic              out_valid;
  logic              out_stall;
  ssbd_out_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  stream_segment_boundary_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow of the register file and of the detector state.
  ssbd_cfg_t cfg_shadow;
  longint    prev_sample;
  longint    last_region;
  longint    page_base;
  int        rows_count;
  int        segment_count;
  int        limit_rows;
  bit        page_open;

  // Results still owed by the block, oldest first.
  ssbd_out_t pending_results [$];
  stim_row_t directed_rows   [$];

  int     error_count;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     holdoff_req;
  longint gen_prev;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #(LIMIT_CYCLES * 10);
    $display("CHECK FAILED");
    $finish;
  end

  // Mirror a register write into the shadow copy, trimmed to field width.
  function automatic void apply_register(input ssbd_reg_t target, input logic [31:0] value);
    case (target)
      REG_BREAK_MODE:    cfg_shadow.break_mode    = value[2:0];
      REG_GAP_AMOUNT:    cfg_shadow.gap_amount    = value[30:0];
      REG_CHANGE_AMOUNT: cfg_shadow.change_amount = value[30:0];
      REG_CHANGE_BASE:   cfg_shadow.change_base   = value;
      REG_BASE_GIVEN:    cfg_shadow.base_given    = value[0];
      REG_ROW_LIMIT:     cfg_shadow.row_limit     = value[15:0];
      default: ;
    endcase
  endfunction

  // Decide whether the sample opens a segment and advance the shadow state.
  function automatic ssbd_out_t predict_boundary(input ssbd_in_t item);
    longint    s;
    longint    base;
    longint    region;
    longint    step;
    longint    mag;
    bit        first;
    bit        brk;
    ssbd_out_t res;
    s     = longint'($signed(item.sample));
    // no page seen since reset: treat the sample as a page start
    first = item.first_of_page || !page_open;
    if (first) page_base = s;
    base   = cfg_shadow.base_given ? longint'($signed(cfg_shadow.change_base)) : page_base;
    region = (cfg_shadow.change_amount == '0) ? 0
             : (s - base) / longint'(cfg_shadow.change_amount);
    step   = s - prev_sample;
    mag    = (step < 0) ? -step : step;
    brk    = 1'b0;
    if (first) begin
      brk = 1'b1;
    end else begin
      case (cfg_shadow.break_mode)
        MODE_GAP:       brk = mag >= longint'(cfg_shadow.gap_amount);
        MODE_INCREASE:  brk = s > prev_sample;
        MODE_DECREASE:  brk = s < prev_sample;
        MODE_CHANGE:    brk = (cfg_shadow.change_amount == '0) ? (s != prev_sample)
                              : (region != last_region);
        MODE_ROW_LIMIT: brk = limit_rows >= int'(cfg_shadow.row_limit);
        default:        brk = 1'b0;
      endcase
    end
    if (first) begin
      segment_count = 0;
      rows_count    = 0;
      limit_rows    = 1;
    end else if (brk) begin
      if (segment_count < COUNT_MAX) segment_count++;
      rows_count = 0;
      limit_rows = 1;
    end else begin
      if (rows_count < COUNT_MAX) rows_count++;
      if (limit_rows < LIMIT_MAX) limit_rows++;
    end
    page_open   = 1'b1;
    prev_sample = s;
    last_region = region;
    res.segment_start  = brk;
    res.segment_number = COUNT_WIDTH'(segment_count);
    res.row_in_segment = COUNT_WIDTH'(rows_count);
    return res;
  endfunction

  // Draw the next random sample: mostly steps around the last one, scaled to
  // the active gap or region width, with page starts and full-range jumps.
  function automatic ssbd_in_t draw_sample();
    ssbd_in_t item;
    longint   scale;
    longint   nxt;
    int       pick;
    item.first_of_page = ($urandom_range(99) < 5);
    pick = $urandom_range(99);
    if (pick < 8) begin
      nxt = longint'($signed($urandom()));
    end else if (pick < 25) begin
      nxt = gen_prev;
    end else begin
      case ($urandom_range(3))
        0:       scale = 16;
        1:       scale = longint'(cfg_shadow.gap_amount);
        2:       scale = longint'(cfg_shadow.change_amount);
        default: scale = 262144;
      endcase
      if (scale < 2) scale = 2;
      if (scale > 64'h3FFF_FFFF) scale = 64'h3FFF_FFFF;
      nxt = gen_prev + longint'($urandom_range(0, int'(2 * scale))) - scale;
    end
    item.sample = nxt[31:0];
    gen_prev    = longint'($signed(item.sample));
    return item;
  endfunction

  task automatic add_write(input ssbd_reg_t target, input logic [31:0] value);
    stim_row_t row;
    row           = '{target: REG_BREAK_MODE, default: '0};
    row.is_write  = 1'b1;
    row.target    = target;
    row.value     = value;
    directed_rows.push_back(row);
  endtask

  task automatic add_item(input logic [31:0] s, input bit first);
    stim_row_t row;
    row                    = '{target: REG_BREAK_MODE, default: '0};
    row.item.sample        = s;
    row.item.first_of_page = first;
    directed_rows.push_back(row);
  endtask

  task automatic add_checked(input logic [31:0] s, input bit first, input bit brk,
                             input int num, input int pos);
    stim_row_t row;
    row                             = '{target: REG_BREAK_MODE, default: '0};
    row.item.sample                 = s;
    row.item.first_of_page          = first;
    row.has_typed                   = 1'b1;
    row.typed_res.segment_start     = brk;
    row.typed_res.segment_number    = COUNT_WIDTH'(num);
    row.typed_res.row_in_segment    = COUNT_WIDTH'(pos);
    directed_rows.push_back(row);
  endtask

  // Two-phase register write: setup, then access until pready.
  task automatic write_register(input ssbd_reg_t target, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {target, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(target, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one item after a random idle stretch; predict once accepted.
  task automatic offer_sample(input ssbd_in_t item, input bit has_typed = 1'b0,
                              input ssbd_out_t typed_res = '0);
    ssbd_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    predicted = predict_boundary(item);
    pending_results.push_back(has_typed ? typed_res : predicted);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Program every register, leaning toward the extremes of each field.
  task automatic randomize_registers(input logic [2:0] mode);
    logic [31:0] gap;
    logic [31:0] width;
    logic [31:0] base;
    logic [31:0] rows;
    case ($urandom_range(5))
      0:       gap = 32'd0;
      1:       gap = 32'd1;
      2:       gap = 32'h7FFF_FFFF;
      default: gap = $urandom_range(1, 32'h0004_0000);
    endcase
    case ($urandom_range(5))
      0:       width = 32'd0;
      1:       width = 32'd1;
      2:       width = 32'h7FFF_FFFF;
      3:       width = $urandom_range(1, 32'h7FFF_FFFF);
      default: width = $urandom_range(32'h100, 32'h0004_0000);
    endcase
    case ($urandom_range(3))
      0:       base = 32'h8000_0000;
      1:       base = 32'h7FFF_FFFF;
      default: base = $urandom();
    endcase
    case ($urandom_range(4))
      0:       rows = 32'd0;
      1:       rows = 32'd1;
      2:       rows = 32'd65535;
      default: rows = $urandom_range(2, 6);
    endcase
    write_register(REG_BREAK_MODE, 32'(mode));
    write_register(REG_GAP_AMOUNT, gap);
    write_register(REG_CHANGE_AMOUNT, width);
    write_register(REG_CHANGE_BASE, base);
    write_register(REG_BASE_GIVEN, 32'($urandom_range(1)));
    write_register(REG_ROW_LIMIT, rows);
  endtask

  // Result side: stall at the phase's rate, or hold off for a requested
  // stretch counted here, so the block backs up into its input.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req > 0) begin
        hold_left   = holdoff_req;
        holdoff_req = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    ssbd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: %p", out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.segment_start !== want.segment_start) begin
          $error("segment_start: expected %0d, got %0d",
                 want.segment_start, out_data.segment_start);
          error_count++;
        end
        if (out_data.segment_number !== want.segment_number) begin
          $error("segment_number: expected %0d, got %0d",
                 want.segment_number, out_data.segment_number);
          error_count++;
        end
        if (out_data.row_in_segment !== want.row_in_segment) begin
          $error("row_in_segment: expected %0d, got %0d",
                 want.row_in_segment, out_data.row_in_segment);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    error_count    = 0;
    holdoff_req    = 0;
    gen_prev       = 0;
    send_idle_pct  = 19;
    recv_stall_pct = 19;
    // register reset values
    cfg_shadow     = '0;
    cfg_shadow.gap_amount = 31'd65536;
    cfg_shadow.row_limit  = 16'd1;
    prev_sample    = 0;
    last_region    = 0;
    page_base      = 0;
    rows_count     = 0;
    segment_count  = 0;
    limit_rows     = 0;
    page_open      = 1'b0;

    // Directed table. Gap mode after reset: the very first sample opens a
    // page without its flag; full-scale steps break, a zero step does not.
    add_checked(32'h0000_0000, 1'b0, 1'b1, 0, 0);
    add_checked(32'h7FFF_FFFF, 1'b0, 1'b1, 1, 0);
    add_checked(32'h8000_0000, 1'b0, 1'b1, 2, 0);
    add_checked(32'h8000_0000, 1'b0, 1'b0, 2, 1);
    add_checked(32'h8000_0000, 1'b1, 1'b1, 0, 0);
    // zero gap: even a zero step breaks
    add_write(REG_GAP_AMOUNT, 32'd0);
    add_checked(32'h8000_0000, 1'b0, 1'b1, 1, 0);
    add_write(REG_GAP_AMOUNT, 32'h7FFF_FFFF);
    add_checked(32'h7FFF_FFFF, 1'b0, 1'b1, 2, 0);
    add_checked(32'h7FFF_FFFE, 1'b0, 1'b0, 2, 1);
    // rule switches within the page from here on
    add_write(REG_BREAK_MODE, 32'(MODE_INCREASE));
    add_item(32'h7FFF_FFFF, 1'b0);
    add_write(REG_BREAK_MODE, 32'(MODE_DECREASE));
    add_item(32'hFFFF_FFFF, 1'b0);
    add_write(REG_BREAK_MODE, 32'(MODE_CHANGE));
    add_item(32'hFFFF_FFFF, 1'b0);
    add_item(32'h0000_0001, 1'b0);
    // region mode with a configured base at the negative extreme
    add_write(REG_CHANGE_AMOUNT, 32'h7FFF_FFFF);
    add_write(REG_CHANGE_BASE, 32'h8000_0000);
    add_write(REG_BASE_GIVEN, 32'd1);
    add_item(32'h7FFF_FFFF, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b1);
    // unit width: the quotient needs 32 bits
    add_write(REG_CHANGE_AMOUNT, 32'd1);
    add_item(32'h7FFF_FFFF, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    // base from the page's first sample
    add_write(REG_BASE_GIVEN, 32'd0);
    add_write(REG_CHANGE_AMOUNT, 32'h0001_0000);
    add_item(32'h0003_0000, 1'b1);
    add_item(32'h0003_8000, 1'b0);
    // row limit zero acts as one: every row breaks
    add_write(REG_BREAK_MODE, 32'(MODE_ROW_LIMIT));
    add_write(REG_ROW_LIMIT, 32'd0);
    add_item(32'h0000_0000, 1'b0);
    add_item(32'h0000_0000, 1'b0);
    add_write(REG_ROW_LIMIT, 32'd2);
    add_item(32'h0000_0000, 1'b0);
    add_item(32'h0000_0000, 1'b0);
    // spare mode code: only page starts break
    add_write(REG_BREAK_MODE, 32'(LAST_SPARE_MODE));
    add_item(32'h0000_0000, 1'b0);
    add_item(32'h0000_0005, 1'b0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the table; drain the block before each register write.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        release_input();
        wait_drained();
        write_register(directed_rows[i].target, directed_rows[i].value);
      end else begin
        offer_sample(directed_rows[i].item, directed_rows[i].has_typed,
                     directed_rows[i].typed_res);
      end
    end

    // Random phases: new register set and idle pattern each time, with the
    // page state carried across so the rule changes mid-page.
    for (int p = 0; p < NUM_PHASES; p++) begin
      release_input();
      wait_drained();
      send_idle_pct  = SEND_IDLE[p % 4];
      recv_stall_pct = RECV_IDLE[p % 4];
      randomize_registers(PHASE_MODE[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold the result side off while items keep coming
        if (p == 0 && n == 60) holdoff_req = HOLDOFF_CYCLES;
        // pause the input until every result is out
        if (p == 1 && n == 90) begin
          release_input();
          wait_drained();
        end
        offer_sample(draw_sample());
      end
    end

    release_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
